// ===== design/tmc_pkg.sv =====
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared types, constants and helpers for the tonearm motion controller.
// ----------------------------------------------------------------------------
package tmc_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int DUTY_BITS      = 7;
    localparam int MODE_BITS      = 4;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [DUTY_BITS-1:0] DUTY_MAX = 7'd100;

    localparam logic [DUTY_BITS-1:0] LIFT_LOWER_RESET     = 7'd65;
    localparam logic [DUTY_BITS-1:0] LIFT_RAISE_RESET     = 7'd80;
    localparam logic [DUTY_BITS-1:0] TRANSPORT_SEEK_RESET = 7'd80;
    localparam logic [DUTY_BITS-1:0] MANUAL_MOVE_RESET    = 7'd60;
    localparam logic [DUTY_BITS-1:0] TRACKING_OFFSET_RESET = 7'd30;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_REST_DOWN  = 4'd0,
        MODE_REST_UP    = 4'd1,
        MODE_PLAYING    = 4'd2,
        MODE_MANUAL     = 4'd3,
        MODE_R_RAISE    = 4'd4,
        MODE_R_CARRY    = 4'd5,
        MODE_R_LOWER    = 4'd6,
        MODE_L_RAISE    = 4'd7,
        MODE_L_BACKOUT  = 4'd8,
        MODE_L_SEEK     = 4'd9,
        MODE_P_LOWER    = 4'd10,
        MODE_C_RAISE    = 4'd11,
        MODE_RC_RAISE   = 4'd12
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LIFT_LOWER      = 3'd0,
        CFG_LIFT_RAISE      = 3'd1,
        CFG_TRANSPORT_SEEK  = 3'd2,
        CFG_MANUAL_MOVE     = 3'd3,
        CFG_TRACKING_OFFSET = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] lift_lower_duty;
        logic [DUTY_BITS-1:0] lift_raise_duty;
        logic [DUTY_BITS-1:0] transport_seek_duty;
        logic [DUTY_BITS-1:0] manual_move_duty;
        logic [DUTY_BITS-1:0] tracking_offset;
    } cfg_t;

    typedef struct packed {
        logic                   at_rest;
        logic                   in_leadin;
        logic                   at_end;
        logic                   lift_is_up;
        logic                   lift_is_down;
        logic                   cue_button;
        logic                   start_button;
        logic                   stop_button;
        logic                   repeat_button;
        logic [SAMPLE_BITS-1:0] track_inner;
        logic [SAMPLE_BITS-1:0] track_outer;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] transport_duty;
        logic                 transport_inward;
        logic [DUTY_BITS-1:0] lift_duty;
        logic                 lift_raising;
        logic [MODE_BITS-1:0] mode;
        logic                 repeat_on;
    } out_item_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty;
        logic                 inward;
    } track_t;

    function automatic logic [DUTY_BITS-1:0] cap_duty(input logic [DUTY_BITS-1:0] v);
        cap_duty = (v > DUTY_MAX) ? DUTY_MAX : v;
    endfunction

endpackage

// ===== design/tmc_cfg.sv =====
// ----------------------------------------------------------------------------
// tmc_cfg
// Duty and offset configuration registers with a plain write port.
// ----------------------------------------------------------------------------
module tmc_cfg
    import tmc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [DUTY_BITS-1:0]      cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LIFT_LOWER:      cfg_next.lift_lower_duty     = cfg_data;
                CFG_LIFT_RAISE:      cfg_next.lift_raise_duty     = cfg_data;
                CFG_TRANSPORT_SEEK:  cfg_next.transport_seek_duty = cfg_data;
                CFG_MANUAL_MOVE:     cfg_next.manual_move_duty    = cfg_data;
                CFG_TRACKING_OFFSET: cfg_next.tracking_offset     = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lift_lower_duty     <= LIFT_LOWER_RESET;
            cfg_reg.lift_raise_duty     <= LIFT_RAISE_RESET;
            cfg_reg.transport_seek_duty <= TRANSPORT_SEEK_RESET;
            cfg_reg.manual_move_duty    <= MANUAL_MOVE_RESET;
            cfg_reg.tracking_offset     <= TRACKING_OFFSET_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/tmc_tracking.sv =====
// ----------------------------------------------------------------------------
// tmc_tracking
// Tracking duty: photodiode difference over 40, toward zero, plus offset.
// ----------------------------------------------------------------------------
module tmc_tracking
    import tmc_pkg::*;
(
    input  logic [SAMPLE_BITS-1:0] track_inner,
    input  logic [SAMPLE_BITS-1:0] track_outer,
    input  logic [DUTY_BITS-1:0]   offset,
    output track_t                 track
);

    // over 40 = shift by 3, then over 5 by reciprocal multiply
    localparam int QW = SAMPLE_BITS - 3;
    localparam int PW = QW + SAMPLE_BITS;
    localparam int SW = ((QW > DUTY_BITS) ? QW : DUTY_BITS) + 1;
    localparam logic [SAMPLE_BITS-1:0] RECIP = SAMPLE_BITS'((2 ** SAMPLE_BITS + 4) / 5);

    logic signed [SAMPLE_BITS:0] diff;
    logic [SAMPLE_BITS:0]        diff_neg;
    logic [SAMPLE_BITS-1:0]      mag;
    logic [QW-1:0]               eighth;
    logic [PW-1:0]               prod;
    logic [QW-1:0]               quot;
    logic [SW-1:0]               sum;

    always_comb
    begin
        diff     = $signed({1'b0, track_inner}) - $signed({1'b0, track_outer});
        diff_neg = -diff;
        mag      = diff[SAMPLE_BITS] ? diff_neg[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
        eighth   = mag[SAMPLE_BITS-1:3];
        prod     = PW'(eighth) * PW'(RECIP);
        quot     = prod[PW-1:SAMPLE_BITS];
        // offset minus a negative error equals offset plus its magnitude
        sum      = SW'(quot) + SW'(offset);
        track.duty   = (sum > SW'(DUTY_MAX)) ? DUTY_MAX : sum[DUTY_BITS-1:0];
        track.inward = !diff[SAMPLE_BITS] && (quot != '0);
    end

endmodule

// ===== design/tmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmc_ctrl
// Arm sequencing state machine, repeat toggle and motor drive selection.
// ----------------------------------------------------------------------------
module tmc_ctrl
    import tmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  in_item_t  item,
    input  cfg_t      cfg,
    input  track_t    track,
    output out_item_t result_next
);

    mode_t state_reg;
    mode_t state_next;
    mode_t state_step;
    logic  repeat_flag_reg;
    logic  repeat_flag_next;
    logic  repeat_flag_step;
    logic  repeat_seen_reg;
    logic  repeat_seen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= MODE_R_RAISE;
            repeat_flag_reg <= 1'b0;
            repeat_seen_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            repeat_flag_reg <= repeat_flag_next;
            repeat_seen_reg <= repeat_seen_next;
        end
    end

    always_comb
    begin
        repeat_flag_step = repeat_flag_reg ^ (item.repeat_button & !repeat_seen_reg);
        state_step       = state_reg;
        result_next.transport_duty   = '0;
        result_next.transport_inward = 1'b1;
        result_next.lift_duty        = '0;
        result_next.lift_raising     = 1'b1;

        unique case (state_reg) inside
            MODE_REST_DOWN:
            begin
                if (item.cue_button)
                    state_step = MODE_RC_RAISE;
                else if (item.start_button)
                    state_step = MODE_L_RAISE;
            end
            MODE_REST_UP:
            begin
                if (item.cue_button || item.stop_button)
                    state_step = MODE_R_LOWER;
                else if (item.start_button)
                    state_step = MODE_L_RAISE;
            end
            MODE_PLAYING:
            begin
                if (item.cue_button)
                    state_step = MODE_C_RAISE;
                else if (item.at_end)
                    state_step = repeat_flag_step ? MODE_L_RAISE : MODE_R_RAISE;
                else if (item.stop_button)
                    state_step = MODE_R_RAISE;
                else
                begin
                    result_next.transport_duty   = track.duty;
                    result_next.transport_inward = track.inward;
                end
            end
            MODE_MANUAL:
            begin
                if (item.cue_button)
                    state_step = MODE_P_LOWER;
                else if (item.stop_button)
                begin
                    if (!item.in_leadin)
                        state_step = MODE_R_RAISE;
                    else
                    begin
                        result_next.transport_duty   = cap_duty(cfg.manual_move_duty);
                        result_next.transport_inward = 1'b0;
                    end
                end
                else if (item.start_button && !item.at_end)
                begin
                    result_next.transport_duty   = cap_duty(cfg.manual_move_duty);
                    result_next.transport_inward = 1'b1;
                end
            end
            MODE_R_CARRY:
            begin
                if (item.at_rest)
                    state_step = MODE_R_LOWER;
                else
                begin
                    result_next.transport_duty   = cap_duty(cfg.transport_seek_duty);
                    result_next.transport_inward = 1'b0;
                end
            end
            MODE_R_LOWER, MODE_P_LOWER:
            begin
                if (item.lift_is_down)
                    state_step = (state_reg == MODE_R_LOWER) ? MODE_REST_DOWN : MODE_PLAYING;
                else
                begin
                    result_next.lift_duty    = cap_duty(cfg.lift_lower_duty);
                    result_next.lift_raising = 1'b0;
                end
            end
            MODE_L_BACKOUT:
            begin
                if (!item.in_leadin)
                    state_step = MODE_L_SEEK;
                else
                begin
                    result_next.transport_duty   = cap_duty(cfg.transport_seek_duty);
                    result_next.transport_inward = 1'b0;
                end
            end
            MODE_L_SEEK:
            begin
                if (item.in_leadin)
                    state_step = MODE_P_LOWER;
                else
                begin
                    result_next.transport_duty   = cap_duty(cfg.transport_seek_duty);
                    result_next.transport_inward = 1'b1;
                end
            end
            default:
            begin
                // raise states, and any stray code behaves as raise for rest
                if (item.lift_is_up)
                begin
                    if (state_reg == MODE_L_RAISE)
                        state_step = MODE_L_BACKOUT;
                    else if (state_reg == MODE_C_RAISE)
                        state_step = MODE_MANUAL;
                    else if (state_reg == MODE_RC_RAISE)
                        state_step = MODE_REST_UP;
                    else
                        state_step = MODE_R_CARRY;
                end
                else
                begin
                    result_next.lift_duty    = cap_duty(cfg.lift_raise_duty);
                    result_next.lift_raising = 1'b1;
                end
            end
        endcase

        result_next.mode      = state_step;
        result_next.repeat_on = repeat_flag_step;

        state_next       = advance ? state_step : state_reg;
        repeat_flag_next = advance ? repeat_flag_step : repeat_flag_reg;
        repeat_seen_next = advance ? item.repeat_button : repeat_seen_reg;
    end

endmodule

// ===== design/tonearm_motion_controller_core.sv =====
// ----------------------------------------------------------------------------
// tonearm_motion_controller_core
// Pipeline: sample register, then result register; throughput one sample per
//   cycle, set by the single pass of state machine and tracking arithmetic
//   between the two registers, held off only by result stall.
// Reset: asynchronous, active low; arm sequence starts in raise for rest,
//   repeat off, configuration registers back to their default duties.
// ----------------------------------------------------------------------------
module tonearm_motion_controller_core
    import tmc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_stall,
    input  in_item_t                  sample,
    output logic                      result_valid,
    input  logic                      result_stall,
    output out_item_t                 result,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [DUTY_BITS-1:0]      cfg_data
);

    logic      stage_valid_reg;
    logic      stage_valid_next;
    in_item_t  stage_reg;
    logic      result_valid_reg;
    logic      result_valid_next;
    out_item_t result_reg;
    out_item_t result_next;
    logic      advance;
    logic      take;
    cfg_t      cfg;
    track_t    track;

    tmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tmc_tracking u_tracking (
        .track_inner (stage_reg.track_inner),
        .track_outer (stage_reg.track_outer),
        .offset      (cfg.tracking_offset),
        .track       (track)
    );

    tmc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (stage_reg),
        .cfg         (cfg),
        .track       (track),
        .result_next (result_next)
    );

    always_comb
    begin
        advance           = stage_valid_reg && (!result_valid_reg || !result_stall);
        sample_stall      = stage_valid_reg && !advance;
        take              = sample_valid && !sample_stall;
        stage_valid_next  = take || (stage_valid_reg && !advance);
        result_valid_next = advance || (result_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            stage_reg <= sample;
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== design/tmc_checker.sv =====
// ----------------------------------------------------------------------------
// tmc_checker
// Port-level checks on the tonearm motion controller results.
// ----------------------------------------------------------------------------
module tmc_checker
    import tmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      result_valid,
    input  logic      result_stall,
    input  out_item_t result
);

    // a stalled result stays on offer
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // both duties saturate
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.transport_duty <= DUTY_MAX) && (result.lift_duty <= DUTY_MAX))
        else $error("duty above full scale");

    // only one motor is driven per tick
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.transport_duty == '0) || (result.lift_duty == '0))
        else $error("transport and lift driven together");

    // unused mode codes are never entered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.mode <= 4'(MODE_RC_RAISE)))
        else $error("mode code out of range");

    // lift moves only in raise or lower states
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.lift_duty != '0) |->
            (result.mode == 4'(MODE_R_RAISE)) || (result.mode == 4'(MODE_L_RAISE))
            || (result.mode == 4'(MODE_C_RAISE)) || (result.mode == 4'(MODE_RC_RAISE))
            || (result.mode == 4'(MODE_R_LOWER)) || (result.mode == 4'(MODE_P_LOWER)))
        else $error("lift driven outside a lift state");

endmodule

bind tonearm_motion_controller_core tmc_checker u_tmc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
